/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants and types for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;
    localparam int IO_BITS       = 32;
    localparam int OP_BITS       = 4;

    localparam logic [OP_BITS-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_BITS-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_BITS-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_BITS-1:0] OP_MIN  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_MAX  = 4'd5;
    localparam logic [OP_BITS-1:0] OP_INC  = 4'd6;
    localparam logic [OP_BITS-1:0] OP_DEC  = 4'd7;
    localparam logic [OP_BITS-1:0] OP_FINT = 4'd8;
    localparam logic [OP_BITS-1:0] OP_TINT = 4'd9;

    // flags that ride along with every item
    typedef struct packed {
        logic less;
        logic equal;
        logic greater;
    } cmp_t;

endpackage

/* rtl/fixed_point_alu_unit.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec, conversions.
// ----------------------------------------------------------------------------
// Every operation goes through one fixed-length pipeline of WORD_BITS+FRAC_BITS
// divider stages plus four more (operand prep, multiply, rounding, saturation
// into the output register), the same for every op, and a new transfer is
// taken in every cycle while the output is not stalled. The depth is set by the
// restoring divider, which resolves one quotient bit per stage. The whole
// pipe advances only when the output register is empty or being drained.
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fpa_pkg::OP_BITS-1:0]      op,
    input  logic signed [fpa_pkg::IO_BITS-1:0] operand_a,
    input  logic signed [fpa_pkg::IO_BITS-1:0] operand_b,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [fpa_pkg::IO_BITS-1:0] result,
    output logic                             less,
    output logic                             equal,
    output logic                             greater,
    output logic                             div_zero,
    output logic                             overflow
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NB = W + F;
    localparam int DB = W + 1;
    localparam int PB = 2 * W;
    localparam int XB = PB + 2;
    localparam int SB = fpa_pkg::OP_BITS + 3 + 1 + 1 + W + W + PB;

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // ---- stage 1: operand prep ----
    logic                       v1_reg;
    logic [fpa_pkg::OP_BITS-1:0] op1_reg;
    logic signed [W-1:0]        a1_reg, b1_reg;
    logic [W-1:0]               ma1_reg, mb1_reg;
    fpa_pkg::cmp_t              c1_reg;
    logic signed [W-1:0]        aw, bw;
    logic [W-1:0]               maw, mbw;

    assign aw  = operand_a[W-1:0];
    assign bw  = operand_b[W-1:0];
    assign maw = aw[W-1] ? W'(-aw) : W'(aw);
    assign mbw = bw[W-1] ? W'(-bw) : W'(bw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg  <= op;
            a1_reg   <= aw;
            b1_reg   <= bw;
            ma1_reg  <= maw;
            mb1_reg  <= mbw;
            c1_reg.less    <= aw < bw;
            c1_reg.equal   <= aw == bw;
            c1_reg.greater <= aw > bw;
        end
    end

    // ---- stage 2: multiply of magnitudes ----
    logic                       v2_reg;
    logic [fpa_pkg::OP_BITS-1:0] op2_reg;
    logic signed [W-1:0]        a2_reg, b2_reg;
    logic [W-1:0]               ma2_reg, mb2_reg;
    fpa_pkg::cmp_t              c2_reg;
    logic [PB-1:0]              p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg <= op1_reg;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            ma2_reg <= ma1_reg;
            mb2_reg <= mb1_reg;
            c2_reg  <= c1_reg;
            p2_reg  <= PB'(ma1_reg) * PB'(mb1_reg);
        end
    end

    // ---- divider: |a|<<F / |b|, quotient and remainder ----
    logic [NB-1:0] dnum;
    logic [DB-1:0] dden;
    logic [SB-1:0] side_in, side_out;
    logic          dv;
    logic [NB-1:0] dq;
    logic [DB-1:0] dr, dd;

    assign dnum    = {ma2_reg, F'(0)};
    assign dden    = {1'b0, mb2_reg};
    assign side_in = {op2_reg, c2_reg, a2_reg[W-1], b2_reg[W-1], a2_reg, b2_reg, p2_reg};

    fpa_div #(.NB(NB), .DB(DB), .SB(SB)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .num      (dnum),
        .den      (dden),
        .side_in  (side_in),
        .out_valid(dv),
        .quo      (dq),
        .rem      (dr),
        .den_out  (dd),
        .side_out (side_out)
    );

    logic [fpa_pkg::OP_BITS-1:0] op3;
    fpa_pkg::cmp_t               c3;
    logic                        sa3, sb3;
    logic signed [W-1:0]         a3, b3;
    logic [PB-1:0]               p3;
    assign {op3, c3, sa3, sb3, a3, b3, p3} = side_out;

    // ---- stage 3: rounding and pre-saturation value ----
    logic                       v4_reg;
    logic [fpa_pkg::OP_BITS-1:0] op4_reg;
    fpa_pkg::cmp_t              c4_reg;
    logic signed [XB-1:0]       x4_reg;
    logic                       dz4_reg;
    logic signed [XB-1:0]       x_next;
    logic                       dz_next;
    logic [PB-1:0]              pm;
    logic [NB:0]                qm;
    logic                       neg;

    always_comb
    begin
        neg     = sa3 != sb3;
        dz_next = 1'b0;
        pm      = (p3 + (PB'(1) << (F - 1))) >> F;
        // round up when 2*rem >= den
        qm      = {1'b0, dq} + (NB+1)'(({dr, 1'b0} >= {1'b0, dd}) ? 1 : 0);
        x_next  = '0;
        case (op3)
            fpa_pkg::OP_ADD:  x_next = XB'(a3) + XB'(b3);
            fpa_pkg::OP_SUB:  x_next = XB'(a3) - XB'(b3);
            fpa_pkg::OP_MUL:  x_next = neg ? -XB'($signed({1'b0, pm}))
                                           : XB'($signed({1'b0, pm}));
            fpa_pkg::OP_DIV:
            begin
                if (b3 == '0)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    x_next = neg ? -XB'($signed({1'b0, qm})) : XB'($signed({1'b0, qm}));
                end
            end
            fpa_pkg::OP_MIN:  x_next = c3.less ? XB'(a3) : XB'(b3);
            fpa_pkg::OP_MAX:  x_next = c3.greater ? XB'(a3) : XB'(b3);
            fpa_pkg::OP_INC:  x_next = XB'(a3) + XB'(1);
            fpa_pkg::OP_DEC:  x_next = XB'(a3) - XB'(1);
            fpa_pkg::OP_FINT: x_next = XB'(a3) <<< F;
            fpa_pkg::OP_TINT: x_next = XB'(a3) >>> F;
            default:          x_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op4_reg <= op3;
            c4_reg  <= c3;
            x4_reg  <= x_next;
            dz4_reg <= dz_next;
        end
    end

    // ---- stage 4: saturation into output register ----
    localparam logic signed [XB-1:0] HI = XB'((64'(1) << (W - 1)) - 64'(1));
    localparam logic signed [XB-1:0] LO = -HI - XB'(1);

    logic signed [W-1:0]        res_next;
    logic                       ovf_next;
    logic                       out_valid_reg;
    logic signed [fpa_pkg::IO_BITS-1:0] result_reg;
    fpa_pkg::cmp_t              c5_reg;
    logic                       dz5_reg, ovf5_reg;

    always_comb
    begin
        ovf_next = 1'b0;
        res_next = x4_reg[W-1:0];
        if (x4_reg > HI)
        begin
            ovf_next = 1'b1;
            res_next = HI[W-1:0];
        end
        else if (x4_reg < LO)
        begin
            ovf_next = 1'b1;
            res_next = LO[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= fpa_pkg::IO_BITS'(res_next);
            c5_reg     <= c4_reg;
            dz5_reg    <= dz4_reg;
            ovf5_reg   <= ovf_next && (op4_reg != fpa_pkg::OP_TINT);
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign less      = c5_reg.less;
    assign equal     = c5_reg.equal;
    assign greater   = c5_reg.greater;
    assign div_zero  = dz5_reg;
    assign overflow  = ovf5_reg;

endmodule

/* rtl/fpa_div.sv */
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider for magnitudes, one quotient bit per stage.
// Holds a side word that travels with each item.
// ----------------------------------------------------------------------------
module fpa_div #(
    parameter int NB = 48,
    parameter int DB = 33,
    parameter int SB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    input  logic [SB-1:0] side_in,
    output logic          out_valid,
    output logic [NB-1:0] quo,
    output logic [DB-1:0] rem,
    output logic [DB-1:0] den_out,
    output logic [SB-1:0] side_out
);

    // links between stages; index 0 is the divider input
    wire          v_lnk [NB+1];
    wire [NB-1:0] q_lnk [NB+1];
    wire [NB-1:0] n_lnk [NB+1];
    wire [DB-1:0] r_lnk [NB+1];
    wire [DB-1:0] d_lnk [NB+1];
    wire [SB-1:0] s_lnk [NB+1];

    assign v_lnk[0] = in_valid;
    assign q_lnk[0] = '0;
    assign n_lnk[0] = num;
    assign r_lnk[0] = '0;
    assign d_lnk[0] = den;
    assign s_lnk[0] = side_in;

    genvar i;
    generate
        for (i = 0; i < NB; i++)
        begin : g_st
            logic [DB:0]   trial;
            logic          v_reg;
            logic [NB-1:0] q_reg;
            logic [NB-1:0] n_reg;
            logic [DB-1:0] r_reg;
            logic [DB-1:0] d_reg;
            logic [SB-1:0] s_reg;
            assign trial = {r_lnk[i], n_lnk[i][NB-1]};
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg <= 1'b0;
                end
                else if (en)
                begin
                    v_reg <= v_lnk[i];
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg <= {n_lnk[i][NB-2:0], 1'b0};
                    d_reg <= d_lnk[i];
                    s_reg <= s_lnk[i];
                    if (trial >= {1'b0, d_lnk[i]})
                    begin
                        r_reg <= DB'(trial - {1'b0, d_lnk[i]});
                        q_reg <= {q_lnk[i][NB-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg <= trial[DB-1:0];
                        q_reg <= {q_lnk[i][NB-2:0], 1'b0};
                    end
                end
            end
            assign v_lnk[i+1] = v_reg;
            assign q_lnk[i+1] = q_reg;
            assign n_lnk[i+1] = n_reg;
            assign r_lnk[i+1] = r_reg;
            assign d_lnk[i+1] = d_reg;
            assign s_lnk[i+1] = s_reg;
        end
    endgenerate

    assign out_valid = v_lnk[NB];
    assign quo       = q_lnk[NB];
    assign rem       = r_lnk[NB];
    assign den_out   = d_lnk[NB];
    assign side_out  = s_lnk[NB];

endmodule
